// File: rtl/core/flc_pkg.sv
// flc_pkg: shared types and constants of the fifo link flow completion block
// used by every module under rtl/core except flc_ram; depends on nothing

package flc_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TIME_W          = 32;
    localparam int SUM_W           = 64;
    localparam int OCC_W           = 7;
    localparam int ENTRY_W         = 2 * TIME_W;

    localparam logic [TIME_W-1:0] LINK_SPEED_RST = 32'd1;

    localparam logic MODE_ACCEPT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] created_at;
        logic [TIME_W-1:0] flow_size;
    } in_item_t;

    typedef struct packed {
        logic              completed;
        logic [TIME_W-1:0] completion_span;
        logic [SUM_W-1:0]  span_total;
        logic [TIME_W-1:0] finished_count;
        logic [TIME_W-1:0] next_event;
        logic [OCC_W-1:0]  occupancy;
        logic              dropped;
    } out_result_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic push;
        logic drop;
        logic rd_head;
        logic div_start;
        logic fin_load;
        logic pop;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic full;
        logic empty;
        logic div_done;
        logic fin_due;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/core/fifo_link_flow_completion.sv
// fifo_link_flow_completion: top level, joins the sequencer and the datapath
// depends on flc_pkg, flc_ctrl and flc_dp

// One link serving flows first in, first out. A request with mode 0 queues a
// flow (dropped and flagged when the queue holds QUEUE_DEPTH flows); mode 1 is a
// time tick that retires the head flow when its finish time, service start plus
// flow_size / link_speed, is at or before now. Every request gives exactly one
// result. One request is worked on at a time; how long it takes is set by the
// one-bit-per-cycle 32-bit divider, run once per finish-time evaluation, plus
// the registered read of the flow store. A finished result waits in an output
// register, so the next request is taken while it is still stalled.
// link_speed is written through the cfg port only between requests.

module fifo_link_flow_completion #(
    parameter int QUEUE_DEPTH = flc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  flc_pkg::in_item_t           in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output flc_pkg::out_result_t        out_result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [flc_pkg::TIME_W-1:0]  cfg_data
);

    flc_pkg::cmd_t  cmd;
    flc_pkg::stat_t stat;
    logic           idle;

    flc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .idle     (idle),
        .stat     (stat),
        .cmd      (cmd)
    );

    flc_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_item    (in_item),
        .cfg_write  (cfg_valid && idle),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign in_stall  = !idle;
    assign cfg_ready = idle;

endmodule

// File: rtl/core/flc_ram.sv
// flc_ram: generic single write port, single read port ram with registered read
// no package dependency

module flc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/flc_div.sv
// flc_div: restoring divider, one quotient bit per cycle
// depends on flc_pkg for the operand width

module flc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [flc_pkg::TIME_W-1:0]  dividend,
    input  logic [flc_pkg::TIME_W-1:0]  divisor,
    output logic                        done,
    output logic [flc_pkg::TIME_W-1:0]  quotient
);

    localparam int W   = flc_pkg::TIME_W;
    localparam int CNT = $clog2(W + 1);

    logic [CNT-1:0] cnt_reg;
    logic [CNT-1:0] cnt_next;
    logic           done_reg;
    logic           done_next;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   rem_next;
    logic [W-1:0]   quo_reg;
    logic [W-1:0]   quo_next;
    logic [W-1:0]   den_reg;
    logic [W-1:0]   den_next;
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           ge;

    // a zero divisor leaves every trial at or above it, so the quotient is all ones
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next = CNT'(W);
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT'(1);
            done_next = (cnt_reg == CNT'(1));
            rem_next  = ge ? diff[W-1:0] : trial[W-1:0];
            quo_next  = {quo_reg[W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/flc_dp.sv
// flc_dp: queue pointers, flow store, divider, statistics and result register
// depends on flc_pkg, flc_ram and flc_div

module flc_dp #(
    parameter int QUEUE_DEPTH = flc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  flc_pkg::cmd_t               cmd,
    output flc_pkg::stat_t              stat,
    input  flc_pkg::in_item_t           in_item,
    input  logic                        cfg_write,
    input  logic [flc_pkg::TIME_W-1:0]  cfg_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output flc_pkg::out_result_t        out_result
);

    localparam int W  = flc_pkg::TIME_W;
    localparam int SW = flc_pkg::SUM_W;
    localparam int OW = flc_pkg::OCC_W;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    flc_pkg::in_item_t    item_reg;
    flc_pkg::out_result_t out_result_reg;
    logic                 out_valid_reg;

    logic [W-1:0]  link_speed_reg;
    logic [PW-1:0] head_ptr_reg;
    logic [PW-1:0] tail_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [W-1:0]  service_start_reg;
    logic [SW-1:0] span_sum_reg;
    logic [W-1:0]  done_count_reg;
    logic [W-1:0]  finish_reg;
    logic          completed_reg;
    logic [W-1:0]  span_reg;
    logic          dropped_reg;

    logic [flc_pkg::ENTRY_W-1:0] ram_rdata;
    logic [W-1:0]  div_q;
    logic          div_done;
    logic [W:0]    finish_sum;
    logic [W-1:0]  head_created;
    logic [W-1:0]  span_now;
    logic [SW:0]   total_sum;
    logic          empty;
    logic [OW+CW-1:0] occ_wide;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    flc_ram #(
        .WIDTH (flc_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tail_ptr_reg),
        .wdata ({item_reg.created_at, item_reg.flow_size}),
        .re    (cmd.rd_head),
        .raddr (head_ptr_reg),
        .rdata (ram_rdata)
    );

    flc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (ram_rdata[W-1:0]),
        .divisor  (link_speed_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign empty        = (count_reg == '0);
    assign finish_sum   = {1'b0, service_start_reg} + {1'b0, div_q};
    assign head_created = ram_rdata[2*W-1:W];
    assign span_now     = (item_reg.now >= head_created) ? item_reg.now - head_created : '0;
    assign total_sum    = {1'b0, span_sum_reg} + {{(SW - W + 1){1'b0}}, span_now};
    assign occ_wide     = {{OW{1'b0}}, count_reg};

    assign stat.is_tick  = (item_reg.mode == flc_pkg::MODE_TICK);
    assign stat.full     = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty    = empty;
    assign stat.div_done = div_done;
    assign stat.fin_due  = (finish_reg <= item_reg.now);
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_speed_reg    <= flc_pkg::LINK_SPEED_RST;
            head_ptr_reg      <= '0;
            tail_ptr_reg      <= '0;
            count_reg         <= '0;
            service_start_reg <= '0;
            span_sum_reg      <= '0;
            done_count_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                link_speed_reg <= cfg_data;
            end
            if (cmd.push)
            begin
                tail_ptr_reg <= ptr_inc(tail_ptr_reg);
                count_reg    <= count_reg + CW'(1);
                if (empty)
                begin
                    service_start_reg <= item_reg.now;
                end
            end
            if (cmd.pop)
            begin
                head_ptr_reg      <= ptr_inc(head_ptr_reg);
                count_reg         <= count_reg - CW'(1);
                // only matters while flows remain
                service_start_reg <= item_reg.now;
                span_sum_reg      <= total_sum[SW] ? '1 : total_sum[SW-1:0];
                if (done_count_reg != '1)
                begin
                    done_count_reg <= done_count_reg + W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg      <= in_item;
            completed_reg <= 1'b0;
            span_reg      <= '0;
            dropped_reg   <= 1'b0;
        end
        if (cmd.drop)
        begin
            dropped_reg <= 1'b1;
        end
        if (cmd.pop)
        begin
            completed_reg <= 1'b1;
            span_reg      <= span_now;
        end
        if (cmd.fin_load)
        begin
            finish_reg <= finish_sum[W] ? '1 : finish_sum[W-1:0];
        end
        if (cmd.out_load)
        begin
            out_result_reg.completed       <= completed_reg;
            out_result_reg.completion_span <= span_reg;
            out_result_reg.span_total      <= span_sum_reg;
            out_result_reg.finished_count  <= done_count_reg;
            out_result_reg.next_event      <= empty ? '1 : finish_reg;
            out_result_reg.occupancy       <= occ_wide[OW-1:0];
            out_result_reg.dropped         <= dropped_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// File: rtl/core/flc_ctrl.sv
// flc_ctrl: sequencer that steps one request through queue update and finish check
// depends on flc_pkg for the command and status structs

module flc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           idle,
    input  flc_pkg::stat_t stat,
    output flc_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_NEXT = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_RDW  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       decide_reg;
    logic       decide_next;

    always_comb
    begin
        state_next  = state_reg;
        decide_next = decide_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!stat.is_tick)
                begin
                    cmd.drop   = stat.full;
                    cmd.push   = !stat.full;
                    state_next = S_NEXT;
                end
                else if (stat.empty)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    decide_next = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_NEXT:
            begin
                decide_next = 1'b0;
                state_next  = stat.empty ? S_OUT : S_RD;
            end
            S_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_RDW;
            end
            S_RDW:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.fin_load = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                // on a tick whose head finish is due: retire it, then recompute for the new head if one remains
                if (decide_reg && stat.fin_due)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            decide_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            decide_reg <= decide_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule

// File: rtl/core/flc_chk.sv
// flc_chk: port-level checks on the fifo link flow completion block, bound to the top
// depends on flc_pkg for the payload types

module flc_chk #(
    parameter int QUEUE_DEPTH = flc_pkg::QUEUE_DEPTH_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input flc_pkg::out_result_t        out_result,
    input logic                        cfg_ready
);

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_result))
        else $error("result changed while stalled");

    // one request at a time: busy right after taking one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !cfg_ready)
        else $error("request taken while previous one still in work");

    a_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_result.completed |-> out_result.completion_span == '0)
        else $error("nonzero span without completion");

    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_result.dropped |-> !out_result.completed)
        else $error("drop and completion on the same request");

    // empty queue reports no next event
    a_empty_next: assert property (@(posedge clk) disable iff (!rst_n)
        (QUEUE_DEPTH < 128) && out_valid && out_result.occupancy == '0
        |-> out_result.next_event == '1)
        else $error("empty queue with a next event");

endmodule

bind fifo_link_flow_completion flc_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_flc_chk (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for fifo_link_flow_completion, one link serving flows in order
// depends on flc_pkg and the fifo_link_flow_completion rtl; predicts every result in-line

module testbench;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 3000;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          in_valid   = 1'b0;
    logic                          in_stall;
    flc_pkg::in_item_t             in_item    = '0;
    logic                          out_valid;
    logic                          out_stall  = 1'b0;
    flc_pkg::out_result_t          out_result;
    logic                          cfg_valid  = 1'b0;
    logic                          cfg_ready;
    logic [flc_pkg::TIME_W-1:0]    cfg_data   = '0;

    fifo_link_flow_completion uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // link state as the block should hold it
    logic [flc_pkg::TIME_W-1:0] flow_created [flc_pkg::QUEUE_DEPTH_DEF];
    logic [flc_pkg::TIME_W-1:0] flow_bytes   [flc_pkg::QUEUE_DEPTH_DEF];
    int                         q_head      = 0;
    int                         q_tail      = 0;
    int                         q_count     = 0;
    logic [flc_pkg::TIME_W-1:0] svc_start   = '0;
    logic [flc_pkg::SUM_W-1:0]  span_acc    = '0;
    logic [flc_pkg::TIME_W-1:0] done_flows  = '0;
    logic [flc_pkg::TIME_W-1:0] speed_reg   = flc_pkg::LINK_SPEED_RST;

    flc_pkg::in_item_t    pending_requests [$];
    flc_pkg::out_result_t predicted_results [$];

    int mismatches    = 0;
    int n_accepts     = 0;
    int n_ticks       = 0;
    int n_done        = 0;
    int n_dropped     = 0;
    int speeds_set    = 0;
    int queued_total  = 0;
    int cycles        = 0;
    int burst_left    = 1;
    int gap_left      = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int seg_left      = 0;
    int unsigned stall_pct = 0;
    logic [flc_pkg::TIME_W-1:0] gen_now = '0;

    function automatic logic [flc_pkg::TIME_W-1:0] head_due_time();
        logic [flc_pkg::TIME_W-1:0] quot;
        logic [flc_pkg::TIME_W:0]   fin;
        quot = (speed_reg == '0) ? '1 : flow_bytes[q_head] / speed_reg;
        fin  = {1'b0, svc_start} + {1'b0, quot};
        return fin[flc_pkg::TIME_W] ? '1 : fin[flc_pkg::TIME_W-1:0];
    endfunction

    function automatic flc_pkg::out_result_t serve_request(flc_pkg::in_item_t it);
        flc_pkg::out_result_t r;
        logic [flc_pkg::SUM_W:0] sum;
        r = '0;
        if (it.mode == flc_pkg::MODE_ACCEPT)
        begin
            n_accepts++;
            if (q_count >= flc_pkg::QUEUE_DEPTH_DEF)
            begin
                r.dropped = 1'b1;
                n_dropped++;
            end
            else
            begin
                if (q_count == 0)
                    svc_start = it.now;
                flow_created[q_tail] = it.created_at;
                flow_bytes[q_tail]   = it.flow_size;
                q_tail = (q_tail + 1) % flc_pkg::QUEUE_DEPTH_DEF;
                q_count++;
            end
        end
        else
        begin
            n_ticks++;
            if (q_count > 0 && head_due_time() <= it.now)
            begin
                r.completed = 1'b1;
                // flows created after now clamp to a zero span
                r.completion_span = (it.now >= flow_created[q_head]) ?
                                    it.now - flow_created[q_head] : '0;
                sum = {1'b0, span_acc} + (flc_pkg::SUM_W+1)'(r.completion_span);
                span_acc = sum[flc_pkg::SUM_W] ? '1 : sum[flc_pkg::SUM_W-1:0];
                if (done_flows != '1)
                    done_flows++;
                q_head = (q_head + 1) % flc_pkg::QUEUE_DEPTH_DEF;
                q_count--;
                if (q_count > 0)
                    svc_start = it.now;
                n_done++;
            end
        end
        r.span_total     = span_acc;
        r.finished_count = done_flows;
        r.next_event     = (q_count == 0) ? '1 : head_due_time();
        r.occupancy      = flc_pkg::OCC_W'(q_count);
        return r;
    endfunction

    function automatic void check_result(flc_pkg::out_result_t got,
                                         flc_pkg::out_result_t want);
        bit bad;
        bad = (got.completed !== want.completed)
           || (got.completion_span !== want.completion_span)
           || (got.span_total !== want.span_total)
           || (got.finished_count !== want.finished_count)
           || (got.next_event !== want.next_event)
           || (got.occupancy !== want.occupancy)
           || (got.dropped !== want.dropped);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d (expected/actual): completed %0b/%0b span %0d/%0d",
                         mismatches, want.completed, got.completed,
                         want.completion_span, got.completion_span,
                         "\n    total %0d/%0d finished %0d/%0d next %h/%h occ %0d/%0d drop %0b/%0b",
                         want.span_total, got.span_total,
                         want.finished_count, got.finished_count,
                         want.next_event, got.next_event,
                         want.occupancy, got.occupancy, want.dropped, got.dropped);
        end
    endfunction

    // request driver: bursts of random length separated by random, sometimes empty, gaps
    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_stall))
        begin
            if (in_valid)
                predicted_results = {predicted_results, serve_request(in_item)};
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                in_item  <= pending_requests.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_result);
            end
            else
                check_result(out_result, predicted_results.pop_front());
        end
    end

    // receiver stall: segments of varying density, plus long holds on request
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 300);
                case ($urandom_range(4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 70;
                    default: stall_pct = 90;
                endcase
            end
            seg_left--;
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, predicted_results.size());
            $display("FAIL fifo_link_flow_completion");
            $finish;
        end
    end

    task automatic add_flow(logic [flc_pkg::TIME_W-1:0] t,
                            logic [flc_pkg::TIME_W-1:0] created,
                            logic [flc_pkg::TIME_W-1:0] bytes);
        flc_pkg::in_item_t it;
        it.mode       = flc_pkg::MODE_ACCEPT;
        it.now        = t;
        it.created_at = created;
        it.flow_size  = bytes;
        pending_requests = {pending_requests, it};
        queued_total++;
    endtask

    // created_at and flow_size are don't-care on a tick, so fill them with noise
    task automatic add_tick(logic [flc_pkg::TIME_W-1:0] t);
        flc_pkg::in_item_t it;
        it.mode       = flc_pkg::MODE_TICK;
        it.now        = t;
        it.created_at = $urandom;
        it.flow_size  = $urandom;
        pending_requests = {pending_requests, it};
        queued_total++;
    endtask

    // flow size that takes about dur ticks at the current link speed
    function automatic logic [flc_pkg::TIME_W-1:0] bytes_for(int unsigned dur);
        logic [63:0] b;
        if (speed_reg == '0)
            return $urandom;
        b = 64'(dur) * 64'(speed_reg) + 64'($urandom_range(0, speed_reg - 1));
        return (b > 64'hFFFF_FFFF) ? '1 : b[flc_pkg::TIME_W-1:0];
    endfunction

    task automatic fill_queue();
        repeat (flc_pkg::QUEUE_DEPTH_DEF + $urandom_range(1, 4))
        begin
            add_flow(gen_now, gen_now - $urandom_range(0, 20), bytes_for($urandom_range(0, 5)));
            gen_now += 1;
        end
    endtask

    task automatic add_traffic(int n);
        int target;
        int unsigned pick;
        flc_pkg::in_item_t it;
        target = queued_total + n;
        while (queued_total < target)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                it.mode       = 1'($urandom_range(1));
                it.now        = $urandom;
                it.created_at = $urandom;
                it.flow_size  = $urandom;
                pending_requests = {pending_requests, it};
                queued_total++;
            end
            else if (pick < 15)
                fill_queue();
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    // now and then a flow stamped after the current time
                    if ($urandom_range(9) == 0)
                        add_flow(gen_now, gen_now + $urandom_range(1, 100),
                                 bytes_for($urandom_range(0, 25)));
                    else
                        add_flow(gen_now, gen_now - $urandom_range(0, 50),
                                 bytes_for($urandom_range(0, 25)));
                    gen_now += $urandom_range(0, 3);
                end
                repeat ($urandom_range(1, 8))
                begin
                    gen_now += $urandom_range(0, 30);
                    add_tick(gen_now);
                end
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || predicted_results.size() != 0);
    endtask

    task automatic set_link_speed(logic [flc_pkg::TIME_W-1:0] v);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        speed_reg = v;
        speeds_set++;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_link_speed(32'd1);
        add_tick(32'd0);                                   // tick on an empty link
        add_flow(32'd100, 32'd90, 32'd0);
        add_flow(32'd101, 32'd200, 32'd5);                 // created after now
        add_tick(32'd99);
        add_tick(32'd100);
        add_tick(32'd120);                                 // late tick, span clamps
        add_flow(32'hFFFF_FF00, 32'd0, 32'hFFFF_FFFF);     // finish time saturates
        add_tick(32'hFFFF_FFFE);
        add_tick(32'hFFFF_FFFF);
        add_flow(32'd0, 32'hFFFF_FFFF, 32'd7);
        add_tick(32'd7);
        add_tick(32'd7);
        gen_now = 32'd1000;
        add_traffic(130);

        set_link_speed(32'hFFFF_FFFF);
        add_flow(gen_now, gen_now, 32'hFFFF_FFFF);
        add_tick(gen_now + 1);
        add_traffic(100);

        set_link_speed(32'd3);
        fill_queue();
        add_traffic(130);
        hold_requests++;

        set_link_speed(32'd0);
        add_flow(32'd5, 32'd3, 32'd0);
        add_tick(32'hFFFF_FFFE);
        add_tick(32'hFFFF_FFFF);
        add_tick(32'hFFFF_FFFF);
        add_traffic(40);

        set_link_speed($urandom_range(1, 1000));
        add_traffic(150);

        set_link_speed($urandom);
        add_traffic(130);

        wait_idle();
        repeat (100) @(posedge clk);
        mismatches += predicted_results.size();

        $display("covered %0d flow accepts (%0d dropped at a full queue), %0d ticks,",
                 n_accepts, n_dropped, n_ticks);
        $display("%0d completions over %0d link speed settings", n_done, speeds_set);
        if (mismatches == 0)
            $display("PASS fifo_link_flow_completion");
        else
            $display("FAIL fifo_link_flow_completion");
        $finish;
    end

endmodule
